// ----- src/per_cpu_page_free_list_allocator_macros.svh -----
// assertion helpers for the page allocator
// the asserting module provides clk and rst_n
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle
`define PCPFL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define PCPFL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pcpfl_pkg.sv -----
`default_nettype none

package pcpfl_pkg;

  // default sizing
  localparam int unsigned CPUS_DEF       = 8;
  localparam int unsigned NUM_PAGES_DEF  = 32768;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  // region register reset values
  localparam logic [31:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [31:0] REGION_END_RST   = 32'h8800_0000;

  // item op codes
  localparam logic [1:0] OP_FREE  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  cpu;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] page_address;
    logic [1:0]  status;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/per_cpu_page_free_list_allocator.sv -----
`default_nettype none
`include "per_cpu_page_free_list_allocator_macros.svh"

// Per-processor LIFO page allocator. Each processor owns a free list of pages linked
// through a link memory of NUM_PAGES entries with one write port and one registered read
// port; list heads live in flip-flops. One item is in work at a time. A free, an alloc
// that finds no page, a free-range with no whole page and the unused op go from S_EXEC
// straight to S_DONE, which loads their result into the output register; an alloc that
// returns a page passes through S_POP for the link memory read, and a free-range passes
// through S_RANGE once per page pushed, one link memory write per cycle. The next item is
// accepted at the edge after the one that loads the output register, so the block takes
// no new item before the last result is loaded. A finished result waits in the sequencer
// while the output register still holds an item that out_ready has not taken.
// An alloc on an empty list takes over the whole list of the lowest-numbered other
// processor with pages. The link memory is not cleared after reset: entries are only
// ever read after being written, so the block accepts items from the first cycle.
module per_cpu_page_free_list_allocator
  import pcpfl_pkg::*;
#(
  parameter int unsigned CPUS       = CPUS_DEF,
  parameter int unsigned NUM_PAGES  = NUM_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire in_item_t              in_item,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      out_item_t             out_item,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]           cfg_data
);

  localparam int unsigned CW  = $clog2(CPUS);
  localparam int unsigned IW  = $clog2(NUM_PAGES);
  localparam int unsigned NW  = IW + 1;
  localparam int unsigned LG  = $clog2(PAGE_BYTES);
  localparam int unsigned APW = 32 - LG;
  localparam int unsigned PW  = ((IW > APW) ? IW : APW) + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_RANGE,
    S_DONE
  } state_t;

  // first page number of the region, rounded up
  function automatic logic [APW:0] base_of(input logic [31:0] s);
    logic [32:0] sum;
    sum = {1'b0, s} + 33'(PAGE_BYTES - 1);
    return sum[32:LG];
  endfunction

  state_t            state_r;
  logic [1:0]        op_r;
  logic [CW-1:0]     who_r;
  logic [31:0]       addr_r;
  logic [31:0]       start_r;
  logic [31:0]       end_r;
  logic [APW:0]      base_pg_r;
  logic [IW-1:0]     head_r [CPUS];
  logic [CPUS-1:0]   hval_r;
  logic [IW-1:0]     pop_idx_r;
  logic [NW-1:0]     cnt_r;
  logic [NW-1:0]     n_r;
  out_item_t         res_r;
  out_item_t         out_item_r;
  logic              out_valid_r;

  logic [CW-1:0]     who_in;
  logic [APW-1:0]    addr_pg;
  logic [PW-1:0]     free_idx_w;
  logic              free_bad;
  logic [APW-1:0]    end_pg;
  logic [PW-1:0]     fit_w;
  logic              range_over;
  logic [NW-1:0]     n_w;
  logic              found;
  logic [CW-1:0]     sel;
  logic              own_v;
  logic [CW-1:0]     rd_cpu;
  logic [IW-1:0]     head_rd;
  logic [PW-1:0]     pop_sum;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [IW:0]       mem_wdata;
  logic [IW:0]       mem_rdata;
  logic [NW-1:0]     cnt_inc;

  // requesting processor wraps modulo the processor count
  always_comb begin
    logic [4:0] w;
    w = {2'b00, in_item.cpu};
    for (int k = 0; k < 4; k++) begin
      if (w >= 5'(CPUS)) begin
        w = w - 5'(CPUS);
      end
    end
    who_in = w[CW-1:0];
  end

  // free address checks and page number
  assign addr_pg    = addr_r[31:LG];
  assign free_idx_w = PW'(addr_pg) - PW'(base_pg_r);
  assign free_bad   = (addr_r[LG-1:0] != '0) || (addr_r < start_r) || (addr_r >= end_r) ||
                      (free_idx_w >= PW'(NUM_PAGES));

  // whole pages in the region, clipped to the store capacity
  assign end_pg     = end_r[31:LG];
  assign fit_w      = (PW'(end_pg) >= PW'(base_pg_r)) ? (PW'(end_pg) - PW'(base_pg_r)) : '0;
  assign range_over = fit_w > PW'(NUM_PAGES);
  assign n_w        = range_over ? NW'(NUM_PAGES) : fit_w[NW-1:0];

  // lowest-numbered other processor holding pages
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < CPUS; i++) begin
      if (!found && (CW'(i) != who_r) && hval_r[i]) begin
        found = 1'b1;
        sel   = CW'(i);
      end
    end
  end

  // single head read: own list, or the victim list when own is empty
  assign own_v   = hval_r[who_r];
  assign rd_cpu  = own_v ? who_r : sel;
  assign head_rd = head_r[rd_cpu];

  // address of the popped page from the current base
  assign pop_sum = PW'(base_pg_r) + PW'(pop_idx_r);
  assign cnt_inc = cnt_r + NW'(1);

  // link memory writes: single free or one page per cycle of a range
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx_w[IW-1:0];
    mem_wdata = {own_v, head_rd};
    if ((state_r == S_EXEC) && (op_r == OP_FREE) && !free_bad) begin
      mem_we = 1'b1;
    end else if (state_r == S_RANGE) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r[IW-1:0];
    end
  end

  pcpfl_link_ram #(
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (head_rd),
    .rdata (mem_rdata)
  );

  // sequencer, list heads, config and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hval_r      <= '0;
      start_r     <= REGION_START_RST;
      end_r       <= REGION_END_RST;
      base_pg_r   <= base_of(REGION_START_RST);
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_REGION_START: begin
            start_r   <= cfg_data;
            base_pg_r <= base_of(cfg_data);
          end
          CFG_REGION_END: begin
            end_r <= cfg_data;
          end
        endcase
      end

      // output register drains unless a new result loads it this cycle
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_item.op;
            who_r   <= who_in;
            addr_r  <= in_item.address;
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_r.page_address <= '0;
          unique case (op_r)
            OP_FREE: begin
              state_r <= S_DONE;
              if (free_bad) begin
                res_r.status <= ST_BAD;
              end else begin
                res_r.status  <= ST_DONE;
                head_r[who_r] <= free_idx_w[IW-1:0];
                hval_r[who_r] <= 1'b1;
              end
            end
            OP_ALLOC: begin
              if (own_v) begin
                res_r.status <= ST_DONE;
                pop_idx_r    <= head_rd;
                state_r      <= S_POP;
              end else if (found) begin
                // take over the victim list, head moves in the pop cycle
                res_r.status <= ST_DONE;
                hval_r[sel]  <= 1'b0;
                head_r[sel]  <= '0;
                pop_idx_r    <= head_rd;
                state_r      <= S_POP;
              end else begin
                res_r.status <= ST_EMPTY;
                state_r      <= S_DONE;
              end
            end
            OP_RANGE: begin
              cnt_r        <= '0;
              n_r          <= n_w;
              res_r.status <= range_over ? ST_BAD : ST_DONE;
              state_r      <= (n_w != '0) ? S_RANGE : S_DONE;
            end
            default: begin
              // unused op: plain done
              res_r.status <= ST_DONE;
              state_r      <= S_DONE;
            end
          endcase
        end

        S_POP: begin
          head_r[who_r]      <= mem_rdata[IW-1:0];
          hval_r[who_r]      <= mem_rdata[IW];
          res_r.page_address <= {pop_sum[APW-1:0], {LG{1'b0}}};
          state_r            <= S_DONE;
        end

        S_RANGE: begin
          head_r[who_r] <= cnt_r[IW-1:0];
          hval_r[who_r] <= 1'b1;
          cnt_r         <= cnt_inc;
          if (cnt_inc == n_r) begin
            state_r <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_item_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  // checks on the sequencer and results
  `PCPFL_ASSERT_NEXT(a_accept_to_exec, in_valid && in_ready, state_r == S_EXEC, "accepted item did not start")
  `PCPFL_ASSERT_IMPL(a_pop_after_alloc, state_r == S_POP, $past(state_r) == S_EXEC && op_r == OP_ALLOC, "pop without alloc")
  `PCPFL_ASSERT_IMPL(a_range_bound, state_r == S_RANGE, cnt_r < n_r, "range walk past page count")
  `PCPFL_ASSERT_IMPL(a_fail_no_page, out_valid && out_item.status != ST_DONE, out_item.page_address == '0, "failed item carries a page")

endmodule

`default_nettype wire

// ----- src/pcpfl_link_ram.sv -----
`default_nettype none

module pcpfl_link_ram
  import pcpfl_pkg::*;
#(
  parameter int unsigned DEPTH = NUM_PAGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [$clog2(DEPTH):0]     wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output      logic [$clog2(DEPTH):0]     rdata
);

  localparam int unsigned AW = $clog2(DEPTH);

  // each entry: end-of-list valid bit over the next page number
  logic [AW:0] mem_r [DEPTH];
  logic [AW:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
